// ----- design/assert_macros.svh -----
// assertion macros shared by the chandelier exit stops rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ces assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ces assertion failed");

`endif

// ----- design/ces_pkg.sv -----
// shared constants, types and helpers for the chandelier exit stops block
package ces_pkg;

  localparam int WINDOW        = 64;
  localparam int PRICE_BITS    = 32;
  localparam int PTR_BITS      = $clog2(WINDOW);
  localparam int LEN_BITS      = $clog2(WINDOW + 1);
  localparam int SUM_BITS      = PRICE_BITS + PTR_BITS;
  localparam int DIV_STEPS     = (SUM_BITS + 1) / 2;
  localparam int DIV_BITS      = 2 * DIV_STEPS;
  localparam int STEP_BITS     = $clog2(DIV_STEPS + 1);
  localparam int COEFF_BITS    = 4;
  localparam int CFG_LEN_BITS  = 7;
  localparam int CFG_DATA_BITS = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int LONG_BITS     = 37;
  localparam int SHORT_BITS    = 36;

  localparam logic [COEFF_BITS-1:0]   COEFF_RESET  = 4'd3;
  localparam logic [CFG_LEN_BITS-1:0] LENGTH_RESET = 7'd22;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEFFICIENT    = 2'd0,
    CFG_ATR_LENGTH     = 2'd1,
    CFG_EXTREME_LENGTH = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } ces_state_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic scan_issue;
    logic div_load;
    logic div_step;
    logic mul;
    logic out_load;
  } ces_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic out_free;
  } ces_status_t;

  // zero acts as one, anything past the ring depth acts as the depth
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [CFG_LEN_BITS-1:0] len);
    logic [LEN_BITS-1:0] res;
    if (len == '0) begin
      res = LEN_BITS'(1);
    end else if (int'(len) > WINDOW) begin
      res = LEN_BITS'(WINDOW);
    end else begin
      res = LEN_BITS'(len);
    end
    return res;
  endfunction

endpackage

// ----- design/ces_ctrl.sv -----
// sequencing state machine for the chandelier exit stops block
`include "assert_macros.svh"

module ces_ctrl import ces_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ces_status_t sts,
  output ces_cmd_t    cmd
);

  ces_state_t state;
  ces_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_WRITE;
      end
      ST_WRITE:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_next = ST_MUL;
      end
      ST_MUL:      state_next = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_WRITE:    cmd.write = 1'b1;
      ST_SCAN:     cmd.scan_issue = !sts.scan_done;
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_MUL:      cmd.mul = 1'b1;
      ST_OUT:      cmd.out_load = sts.out_free;
      default:     cmd = '0;
    endcase
  end

  `ASSERT_NEXT(a_accept_to_write, clk, rst, state == ST_IDLE && in_valid, state == ST_WRITE)
  `ASSERT_NEXT(a_out_wait_holds, clk, rst, state == ST_OUT && !sts.out_free, state == ST_OUT)

endmodule

// ----- design/ces_dp.sv -----
// ring memory, window scan, serial divider and stop arithmetic
`include "assert_macros.svh"

module ces_dp import ces_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  ces_cmd_t                      cmd,
  output ces_status_t                   sts,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic [PRICE_BITS-1:0]         bar_high,
  input  logic [PRICE_BITS-1:0]         bar_low,
  input  logic [PRICE_BITS-1:0]         prior_close,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [LONG_BITS-1:0]   long_stop,
  output logic [SHORT_BITS-1:0]         short_stop,
  output logic                          windows_full
);

  localparam int ENTRY_BITS = 3 * PRICE_BITS;

  logic [COEFF_BITS-1:0]   coefficient;
  logic [CFG_LEN_BITS-1:0] atr_length;
  logic [CFG_LEN_BITS-1:0] extreme_length;

  logic [PRICE_BITS-1:0] hi_q;
  logic [PRICE_BITS-1:0] lo_q;
  logic [PRICE_BITS-1:0] pc_q;

  logic [ENTRY_BITS-1:0] ring [WINDOW];
  logic [ENTRY_BITS-1:0] mem_q;
  logic [PTR_BITS-1:0]   wp;
  logic [PTR_BITS-1:0]   rd_addr;
  logic [LEN_BITS-1:0]   bars_seen;

  logic [LEN_BITS-1:0]   k;
  logic [LEN_BITS-1:0]   k_d;
  logic                  rd_valid;
  logic [SUM_BITS-1:0]   range_sum;
  logic [PRICE_BITS-1:0] maxh;
  logic [PRICE_BITS-1:0] minl;

  logic [DIV_BITS-1:0]   dvd;
  logic [LEN_BITS-1:0]   rem;
  logic [STEP_BITS-1:0]  step;
  logic [LONG_BITS-1:0]  span;

  logic [LEN_BITS-1:0] la;
  logic [LEN_BITS-1:0] le;
  logic [LEN_BITS-1:0] na;
  logic [LEN_BITS-1:0] ne;
  logic [LEN_BITS-1:0] scan_len;

  logic [PRICE_BITS-1:0] tr;
  logic [PRICE_BITS-1:0] gap_hl;
  logic [PRICE_BITS-1:0] gap_ch;
  logic [PRICE_BITS-1:0] gap_cl;
  logic [PRICE_BITS-1:0] rd_high;
  logic [PRICE_BITS-1:0] rd_low;
  logic [PRICE_BITS-1:0] rd_range;

  logic [LEN_BITS:0]   t1;
  logic [LEN_BITS:0]   t2;
  logic                ge1;
  logic                ge2;
  logic [LEN_BITS-1:0] r1;
  logic [LEN_BITS-1:0] r2;

  logic [COEFF_BITS+DIV_BITS-1:0] prod;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefficient    <= COEFF_RESET;
      atr_length     <= LENGTH_RESET;
      extreme_length <= LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COEFFICIENT:    coefficient    <= cfg_data[COEFF_BITS-1:0];
        CFG_ATR_LENGTH:     atr_length     <= cfg_data[CFG_LEN_BITS-1:0];
        CFG_EXTREME_LENGTH: extreme_length <= cfg_data[CFG_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign la       = eff_len(atr_length);
  assign le       = eff_len(extreme_length);
  assign na       = (la < bars_seen) ? la : bars_seen;
  assign ne       = (le < bars_seen) ? le : bars_seen;
  assign scan_len = (na > ne) ? na : ne;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hi_q <= bar_high;
      lo_q <= bar_low;
      pc_q <= prior_close;
    end
  end

  // true range
  assign gap_hl = (hi_q >= lo_q) ? hi_q - lo_q : '0;
  assign gap_ch = (pc_q >= hi_q) ? pc_q - hi_q : hi_q - pc_q;
  assign gap_cl = (pc_q >= lo_q) ? pc_q - lo_q : lo_q - pc_q;

  always_comb begin
    tr = gap_hl;
    if (gap_ch > tr) tr = gap_ch;
    if (gap_cl > tr) tr = gap_cl;
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      bars_seen <= '0;
    end else if (cmd.write) begin
      wp <= wp + PTR_BITS'(1);
      if (bars_seen < LEN_BITS'(WINDOW)) bars_seen <= bars_seen + LEN_BITS'(1);
    end
  end

  // newest entry sits just behind the write pointer
  assign rd_addr = wp - PTR_BITS'(1) - k[PTR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.write) ring[wp] <= {hi_q, lo_q, tr};
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) mem_q <= ring[rd_addr];
  end

  assign rd_high  = mem_q[ENTRY_BITS-1 -: PRICE_BITS];
  assign rd_low   = mem_q[2*PRICE_BITS-1 -: PRICE_BITS];
  assign rd_range = mem_q[PRICE_BITS-1:0];

  // window scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      k <= '0;
    end else if (cmd.scan_issue) begin
      k <= k + LEN_BITS'(1);
    end
    k_d <= k;
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      range_sum <= '0;
      maxh      <= '0;
      minl      <= '1;
    end else if (rd_valid) begin
      if (k_d < na) range_sum <= range_sum + SUM_BITS'(rd_range);
      if (k_d < ne) begin
        if (rd_high > maxh) maxh <= rd_high;
        if (rd_low < minl) minl <= rd_low;
      end
    end
  end

  // restoring divider, two quotient bits per cycle
  assign t1  = {rem, dvd[DIV_BITS-1]};
  assign ge1 = t1 >= {1'b0, la};
  assign r1  = ge1 ? LEN_BITS'(t1 - {1'b0, la}) : LEN_BITS'(t1);
  assign t2  = {r1, dvd[DIV_BITS-2]};
  assign ge2 = t2 >= {1'b0, la};
  assign r2  = ge2 ? LEN_BITS'(t2 - {1'b0, la}) : LEN_BITS'(t2);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd  <= DIV_BITS'(range_sum);
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[DIV_BITS-3:0], ge1, ge2};
      rem  <= r2;
      step <= step + STEP_BITS'(1);
    end
  end

  // coefficient times atr
  assign prod = {{DIV_BITS{1'b0}}, coefficient} * {{COEFF_BITS{1'b0}}, dvd};

  always_ff @(posedge clk) begin
    if (cmd.mul) span <= prod[LONG_BITS-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      long_stop    <= $signed({{(LONG_BITS-PRICE_BITS){1'b0}}, maxh} - span);
      short_stop   <= {{(SHORT_BITS-PRICE_BITS){1'b0}}, minl} + span[SHORT_BITS-1:0];
      windows_full <= (bars_seen >= la) && (bars_seen >= le);
    end
  end

  assign sts.scan_done = (k == scan_len);
  assign sts.div_done  = (step == STEP_BITS'(DIV_STEPS - 1));
  assign sts.out_free  = !out_valid || !out_stall;

  `ASSERT_IMPL(a_rem_below_len, clk, rst, cmd.div_step, rem < la)
  `ASSERT_IMPL(a_bars_saturate, clk, rst, 1'b1, bars_seen <= LEN_BITS'(WINDOW))
  `ASSERT_IMPL(a_read_in_window, clk, rst, rd_valid, k_d < scan_len)

endmodule

// ----- design/chandelier_exit_stops.sv -----
// top level of the chandelier exit stops block
//
// input channel: in_valid / in_stall with bar_high, bar_low, prior_close
// (unsigned q16.16). a transfer happens when in_valid is high and in_stall low.
// output channel: out_valid / out_stall with long_stop (signed q21.16),
// short_stop (unsigned q20.16) and windows_full, one result per bar.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// 0 coefficient, 1 atr_length, 2 extreme_length, other indexes ignored.
// write config only while no bar is in flight.
// each bar passes through the write, scan, divider load, divide, multiply and
// output states; the scan covers n ring entries, n being the larger of the two
// effective window fills (1 to 64), and reads one ring entry per cycle through
// the single memory read port; the divider retires two quotient bits per cycle.
// one bar is worked at a time; in_stall stays high until the result is
// loaded into the output register, which holds it while out_stall is high.
// reset clears the ring fill, pointer and output valid and loads the
// register defaults (3, 22, 22); no clearing pass is needed.
module chandelier_exit_stops import ces_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [PRICE_BITS-1:0]       bar_high,
  input  logic [PRICE_BITS-1:0]       bar_low,
  input  logic [PRICE_BITS-1:0]       prior_close,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [LONG_BITS-1:0] long_stop,
  output logic [SHORT_BITS-1:0]       short_stop,
  output logic                        windows_full,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

  ces_cmd_t    cmd;
  ces_status_t sts;

  ces_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ces_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bar_high     (bar_high),
    .bar_low      (bar_low),
    .prior_close  (prior_close),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .long_stop    (long_stop),
    .short_stop   (short_stop),
    .windows_full (windows_full)
  );

endmodule

// ----- test/chandelier_exit_stops_tb.sv -----
// testbench for chandelier_exit_stops: directed and random bars checked against a local predictor
`timescale 1ns / 100ps

module chandelier_exit_stops_tb import ces_pkg::*;;

  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PHASES         = 12;
  localparam int BARS_PER_PHASE = 108;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [PRICE_BITS-1:0]   PRICE_MAX = '1;

  typedef struct {
    logic [LONG_BITS-1:0]  stop_long;
    logic [SHORT_BITS-1:0] stop_short;
    logic                  full;
  } stops_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PRICE_BITS-1:0] bar_high = '0;
  logic [PRICE_BITS-1:0] bar_low = '0;
  logic [PRICE_BITS-1:0] prior_close = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [LONG_BITS-1:0] long_stop;
  logic [SHORT_BITS-1:0] short_stop;
  logic windows_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predictor state
  logic [PRICE_BITS-1:0] high_hist [WINDOW];
  logic [PRICE_BITS-1:0] low_hist [WINDOW];
  logic [PRICE_BITS-1:0] range_hist [WINDOW];
  logic [PTR_BITS-1:0] hist_ptr = '0;
  int bars_held = 0;
  logic [COEFF_BITS-1:0] coeff_reg = COEFF_RESET;
  logic [CFG_LEN_BITS-1:0] atr_len_reg = LENGTH_RESET;
  logic [CFG_LEN_BITS-1:0] extreme_len_reg = LENGTH_RESET;

  stops_t pending_stops [$];
  int mismatch_count = 0;
  int bars_checked = 0;
  int cycle_count = 0;
  int stall_left = 4;
  logic rx_calm = 1'b0;
  logic [PRICE_BITS-1:0] walk_price = 32'h0064_0000;
  int unsigned walk_step = 65536;

  chandelier_exit_stops dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .bar_high(bar_high), .bar_low(bar_low), .prior_close(prior_close),
    .out_valid(out_valid), .out_stall(out_stall),
    .long_stop(long_stop), .short_stop(short_stop), .windows_full(windows_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("chandelier_exit_stops_tb: errors");
      $finish;
    end
  end

  function automatic int window_span(input logic [CFG_LEN_BITS-1:0] len);
    int n;
    n = int'(len);
    if (n == 0) n = 1;
    if (n > WINDOW) n = WINDOW;
    return n;
  endfunction

  function automatic stops_t next_stops(input logic [PRICE_BITS-1:0] hi, lo, pc);
    logic [PRICE_BITS-1:0] tr, gap_hi, gap_lo, max_hi, min_lo;
    logic [PTR_BITS-1:0] slot;
    logic [41:0] range_total, avg_range, span;
    int la, le, na, ne;
    stops_t r;
    tr = (hi >= lo) ? hi - lo : '0;
    gap_hi = (pc >= hi) ? pc - hi : hi - pc;
    gap_lo = (pc >= lo) ? pc - lo : lo - pc;
    if (gap_hi > tr) tr = gap_hi;
    if (gap_lo > tr) tr = gap_lo;
    high_hist[hist_ptr] = hi;
    low_hist[hist_ptr] = lo;
    range_hist[hist_ptr] = tr;
    hist_ptr = hist_ptr + 1'b1;
    if (bars_held < WINDOW) bars_held++;
    la = window_span(atr_len_reg);
    le = window_span(extreme_len_reg);
    na = (la < bars_held) ? la : bars_held;
    ne = (le < bars_held) ? le : bars_held;
    range_total = '0;
    for (int k = 0; k < na; k++) begin
      slot = hist_ptr - PTR_BITS'(1) - PTR_BITS'(k);
      range_total += 42'(range_hist[slot]);
    end
    max_hi = '0;
    min_lo = PRICE_MAX;
    for (int k = 0; k < ne; k++) begin
      slot = hist_ptr - PTR_BITS'(1) - PTR_BITS'(k);
      if (high_hist[slot] > max_hi) max_hi = high_hist[slot];
      if (low_hist[slot] < min_lo) min_lo = low_hist[slot];
    end
    avg_range = range_total / 42'(la);
    span = 42'(coeff_reg) * avg_range;
    r.stop_long = LONG_BITS'(42'(max_hi) - span);
    r.stop_short = SHORT_BITS'(42'(min_lo) + span);
    r.full = (bars_held >= la) && (bars_held >= le);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got, want);
    $display("mismatch in %s at bar %0d: got %h, expected %h", field, bars_checked, got, want);
    mismatch_count++;
  endtask

  // output checking and receiver stall pattern
  always @(posedge clk) begin
    stops_t want;
    if (out_valid && !out_stall) begin
      if (pending_stops.size() == 0) begin
        report_mismatch("unexpected transfer", {27'b0, long_stop}, '0);
      end else begin
        want = pending_stops.pop_front();
        if (long_stop !== want.stop_long)
          report_mismatch("long_stop", {27'b0, long_stop}, {27'b0, want.stop_long});
        if (short_stop !== want.stop_short)
          report_mismatch("short_stop", {28'b0, short_stop}, {28'b0, want.stop_short});
        if (windows_full !== want.full)
          report_mismatch("windows_full", {63'b0, windows_full}, {63'b0, want.full});
      end
      bars_checked++;
    end
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 4;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall || rx_calm) begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
    end
  end

  task automatic send_bar(input logic [PRICE_BITS-1:0] hi, lo, pc);
    in_valid <= 1'b1;
    bar_high <= hi;
    bar_low <= lo;
    prior_close <= pc;
    do @(posedge clk); while (in_stall);
    pending_stops.push_back(next_stops(hi, lo, pc));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_stops.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COEFFICIENT:    coeff_reg = data[COEFF_BITS-1:0];
      CFG_ATR_LENGTH:     atr_len_reg = data;
      CFG_EXTREME_LENGTH: extreme_len_reg = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] coeff, atr_len, ext_len);
    write_register(CFG_COEFFICIENT, coeff);
    write_register(CFG_ATR_LENGTH, atr_len);
    write_register(CFG_EXTREME_LENGTH, ext_len);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_bar(output logic [PRICE_BITS-1:0] hi, lo, pc);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      walk_price = walk_price + $urandom_range(0, 2 * walk_step) - walk_step;
      hi = walk_price + $urandom_range(0, walk_step);
      lo = walk_price - $urandom_range(0, walk_step);
      pc = walk_price + $urandom_range(0, 2 * walk_step) - walk_step;
    end else if (kind < 9) begin
      hi = $urandom;
      lo = $urandom;
      pc = $urandom;
    end else begin
      hi = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? PRICE_MAX : $urandom);
      lo = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? PRICE_MAX : $urandom);
      pc = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? PRICE_MAX : $urandom);
    end
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_length();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 7'd1;
      2: return 7'(WINDOW);
      3: return 7'($urandom_range(WINDOW + 1, 127));
      4: return 7'($urandom_range(1, 8));
      default: return 7'($urandom_range(1, WINDOW));
    endcase
  endfunction

  // reset register values, partial windows, price extremes, inverted bars
  task automatic test_bar_extremes();
    send_bar('0, '0, '0);
    send_bar(PRICE_MAX, '0, 32'h8000_0000);
    send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX);
    send_bar(32'h0010_0000, 32'h0020_0000, 32'h0018_0000);
    send_bar(32'h0010_0000, 32'h000f_0000, 32'h0100_0000);
    send_bar(32'h0010_0000, 32'h000f_0000, '0);
    send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    wait_drained();
  endtask

  // register extremes: zero and oversize lengths, coefficient bounds, unused index
  task automatic test_register_extremes();
    configure(7'h7F, 7'd0, 7'd0);
    send_bar('0, PRICE_MAX, '0);
    send_bar(32'h0001_0000, 32'h0000_8000, 32'h0001_8000);
    wait_drained();
    configure(7'd15, 7'd127, 7'd65);
    send_bar(PRICE_MAX, '0, PRICE_MAX);
    send_bar(32'h1234_5678, 32'h1200_0000, 32'h1300_0000);
    wait_drained();
    configure(7'h70, 7'd64, 7'd1);
    send_bar(32'h0002_0000, 32'h0001_0000, 32'h0001_8000);
    send_bar(32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_0000);
    wait_drained();
    configure(7'd1, 7'd1, 7'd64);
    send_bar(32'h0003_0000, 32'h0002_0000, 32'h0002_8000);
    wait_drained();
    write_register(CFG_UNUSED_INDEX, 7'h55);
    cfg_valid <= 1'b0;
    send_bar(32'h0004_0000, 32'h0001_0000, 32'h0005_0000);
    wait_drained();
  endtask

  task automatic test_random_bars();
    logic [PRICE_BITS-1:0] hi, lo, pc;
    int burst_left, gap;
    for (int phase = 0; phase < PHASES; phase++) begin
      configure(7'($urandom_range(0, 127)), pick_length(), pick_length());
      case ($urandom_range(0, 3))
        0: walk_step = 16;
        1: walk_step = 65536;
        2: walk_step = 1 << 24;
        default: walk_step = 1 << 28;
      endcase
      rx_calm = (phase % 4 == 3);
      burst_left = $urandom_range(1, 30);
      for (int n = 0; n < BARS_PER_PHASE; n++) begin
        random_bar(hi, lo, pc);
        send_bar(hi, lo, pc);
        if ((phase == 5 && n == 50) || $urandom_range(0, 149) == 0) begin
          // hold off until the block has returned every result
          wait_drained();
        end else if (phase % 4 != 2) begin
          burst_left--;
          if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 30);
          end
        end
      end
      wait_drained();
    end
    rx_calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      high_hist[i] = '0;
      low_hist[i] = '0;
      range_hist[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_bar_extremes();
    test_register_extremes();
    test_random_bars();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_stops.size() == 0) begin
      $display("chandelier_exit_stops_tb: clean");
    end else begin
      $display("chandelier_exit_stops_tb: errors");
    end
    $finish;
  end

endmodule
